/* design/obsd_pkg.sv */
package obsd_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int BYTES_W   = 8;
	localparam int TICKS_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd512;
	localparam logic [BYTES_W-1:0]  MAX_BYTES_RST = 8'd32;
	localparam logic [TICKS_W-1:0]  TIMEOUT_RST   = 16'd1000;

	localparam logic [2:0] PREAMBLE_ONES = 3'd3;
	localparam logic [2:0] STUFF_RUN     = 3'd5;
	localparam logic [2:0] TOP_BIT       = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_BYTE     = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_END_OK   = 3'd2;
	localparam logic [2:0] ST_END_NONE = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;

	typedef enum logic [2:0] {
		PH_HUNT_ONES = 3'd0,
		PH_HUNT_ZERO = 3'd1,
		PH_DATA      = 3'd2,
		PH_STUFF     = 3'd3,
		PH_SKIP      = 3'd4
	} phase_t;

	typedef struct packed {
		logic [BYTES_W-1:0] max_bytes;
		logic [TICKS_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
		logic [2:0] status;
	} result_t;

endpackage

/* design/optical_bit_stuffing_deframer_unit.sv */
// Optical bit-stuffing deframer: one 10-bit light sample per beat is sliced against
// threshold, the hunt looks for three ones and a zero start bit, then bytes are packed
// MSB first with five-ones stuffing (stuffed zero held two periods). Each input beat
// yields zero or one result beat (byte, packet end or timeout status). A sample is
// registered on acceptance; the deframer state then advances and any result is written
// to the output register once that register is not held stalled. One sample is taken
// every cycle; the input stalls only while a result sits stalled at the output.
// Configuration registers may be written only while the block is idle.
module optical_bit_stuffing_deframer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [obsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [obsd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [obsd_pkg::SAMPLE_W-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      data_byte,
	output logic                            byte_valid,
	output logic                            last,
	output logic [2:0]                      status
);
	import obsd_pkg::*;

	logic [SAMPLE_W-1:0] threshold_q;
	logic [BYTES_W-1:0]  max_bytes_q;
	logic [TICKS_W-1:0]  timeout_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                accept;
	logic                go;
	logic                one_bit;
	logic                res_valid;
	cfg_t                cfg;
	result_t             res;
	result_t             out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			max_bytes_q <= MAX_BYTES_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[SAMPLE_W-1:0];
				CFG_MAX_BYTES: max_bytes_q <= cfg_data[BYTES_W-1:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data[TICKS_W-1:0];
				default:       threshold_q <= threshold_q;
			endcase
		end
	end

	// the sample moves on unless a result is waiting in a stalled output register
	assign in_stall = valid_s1 && out_valid && out_stall;
	assign accept   = in_valid && !in_stall;
	assign go       = valid_s1 && !(out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	assign one_bit           = sample_s1 > threshold_q;
	assign cfg.max_bytes     = max_bytes_q;
	assign cfg.timeout_ticks = timeout_q;

	obsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.one_bit   (one_bit),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	obsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign data_byte  = out_res.data_byte;
	assign byte_valid = out_res.byte_valid;
	assign last       = out_res.last;
	assign status     = out_res.status;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid))
		else $error("input stalled without a pending result");

	a_timeout_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_TIMEOUT) |-> (!byte_valid && last && data_byte == 8'd0))
		else $error("timeout beat carries data");

	a_byte_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BYTE) |-> (byte_valid && !last))
		else $error("plain byte beat marked last or empty");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && out_stall) |=> valid_s1)
		else $error("sample lost while output stalled");

endmodule

/* design/obsd_core.sv */
module obsd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic           one_bit,
	input  obsd_pkg::cfg_t cfg,
	output logic           res_valid,
	output obsd_pkg::result_t res
);
	import obsd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [2:0]           run_count_q, run_count_d;
	logic [2:0]           bit_index_q, bit_index_d;
	logic [7:0]           byte_shift_q, byte_shift_d;
	logic [BYTES_W-1:0]   bytes_done_q, bytes_done_d;
	logic [TICKS_W-1:0]   hunt_ticks_q, hunt_ticks_d;

	logic [2:0]           run_inc;
	logic [TICKS_W-1:0]   ticks_inc;
	logic [BYTES_W-1:0]   bytes_inc;
	logic [7:0]           bit_mask;
	logic [7:0]           shift_set;
	logic [7:0]           adv_byte;
	logic                 timed_out;
	logic                 full;
	logic                 do_adv;
	logic                 byte_end;

	assign run_inc   = run_count_q + 3'd1;
	assign ticks_inc = hunt_ticks_q + 16'd1;
	assign bytes_inc = bytes_done_q + 8'd1;
	assign timed_out = ticks_inc >= cfg.timeout_ticks;
	assign full      = bytes_inc >= cfg.max_bytes;
	assign bit_mask  = 8'd1 << bit_index_q;
	assign shift_set = one_bit ? (byte_shift_q | bit_mask) : (byte_shift_q & ~bit_mask);
	assign adv_byte  = (phase_q == PH_DATA) ? shift_set : byte_shift_q;
	assign byte_end  = bit_index_q == 3'd0;

	// the fifth one of a run waits for the stuff check before the bit position moves
	always_comb begin
		do_adv = 1'b0;
		if (phase_q == PH_DATA) begin
			do_adv = !(one_bit && run_inc >= STUFF_RUN);
		end else if (phase_q == PH_STUFF) begin
			do_adv = !one_bit;
		end
	end

	// next state
	always_comb begin
		phase_d      = phase_q;
		run_count_d  = run_count_q;
		bit_index_d  = bit_index_q;
		byte_shift_d = byte_shift_q;
		bytes_done_d = bytes_done_q;
		hunt_ticks_d = hunt_ticks_q;
		unique case (phase_q)
			PH_HUNT_ONES, PH_HUNT_ZERO: begin
				hunt_ticks_d = ticks_inc;
				if (phase_q == PH_HUNT_ONES) begin
					if (one_bit) begin
						run_count_d = run_inc;
						if (run_inc >= PREAMBLE_ONES) begin
							run_count_d = 3'd0;
							phase_d     = PH_HUNT_ZERO;
						end
					end else begin
						run_count_d = 3'd0;
					end
				end
				if (phase_q == PH_HUNT_ZERO && !one_bit) begin
					phase_d      = PH_DATA;
					run_count_d  = 3'd0;
					bit_index_d  = TOP_BIT;
					byte_shift_d = 8'd0;
					bytes_done_d = '0;
					hunt_ticks_d = '0;
				end else if (timed_out) begin
					phase_d      = PH_HUNT_ONES;
					run_count_d  = 3'd0;
					bit_index_d  = TOP_BIT;
					byte_shift_d = 8'd0;
					bytes_done_d = '0;
					hunt_ticks_d = '0;
				end
			end
			PH_DATA, PH_STUFF: begin
				if (phase_q == PH_DATA) begin
					byte_shift_d = shift_set;
					run_count_d  = one_bit ? run_inc : 3'd0;
					if (!do_adv) begin
						phase_d = PH_STUFF;
					end
				end else if (one_bit) begin
					phase_d      = PH_HUNT_ONES;
					run_count_d  = 3'd0;
					bit_index_d  = TOP_BIT;
					byte_shift_d = 8'd0;
					bytes_done_d = '0;
					hunt_ticks_d = '0;
				end else begin
					run_count_d = 3'd0;
					phase_d     = PH_SKIP;
				end
				if (do_adv) begin
					if (!byte_end) begin
						bit_index_d = bit_index_q - 3'd1;
					end else if (full) begin
						phase_d      = PH_HUNT_ONES;
						run_count_d  = 3'd0;
						bit_index_d  = TOP_BIT;
						byte_shift_d = 8'd0;
						bytes_done_d = '0;
						hunt_ticks_d = '0;
					end else begin
						bytes_done_d = bytes_inc;
						byte_shift_d = 8'd0;
						bit_index_d  = TOP_BIT;
					end
				end
			end
			default: begin
				phase_d = PH_DATA;
			end
		endcase
	end

	// result of this sample
	always_comb begin
		res_valid      = 1'b0;
		res.data_byte  = 8'd0;
		res.byte_valid = 1'b0;
		res.last       = 1'b0;
		res.status     = ST_BYTE;
		unique case (phase_q)
			PH_HUNT_ONES, PH_HUNT_ZERO: begin
				if (!(phase_q == PH_HUNT_ZERO && !one_bit) && timed_out) begin
					res_valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_TIMEOUT;
				end
			end
			PH_DATA, PH_STUFF: begin
				if (phase_q == PH_STUFF && one_bit) begin
					res_valid      = 1'b1;
					res.data_byte  = byte_shift_q;
					res.byte_valid = 1'b1;
					res.last       = 1'b1;
					res.status     = (bytes_done_q != '0) ? ST_END_OK : ST_END_NONE;
				end else if (do_adv && byte_end) begin
					res_valid      = 1'b1;
					res.data_byte  = adv_byte;
					res.byte_valid = 1'b1;
					res.last       = full;
					res.status     = full ? ST_FULL : ST_BYTE;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT_ONES;
			run_count_q  <= 3'd0;
			bit_index_q  <= TOP_BIT;
			byte_shift_q <= 8'd0;
			bytes_done_q <= '0;
			hunt_ticks_q <= '0;
		end else if (go) begin
			phase_q      <= phase_d;
			run_count_q  <= run_count_d;
			bit_index_q  <= bit_index_d;
			byte_shift_q <= byte_shift_d;
			bytes_done_q <= bytes_done_d;
			hunt_ticks_q <= hunt_ticks_d;
		end
	end

endmodule

/* design/obsd_out_reg.sv */
module obsd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  obsd_pkg::result_t res,
	input  logic              out_stall,
	output logic              out_valid,
	output obsd_pkg::result_t out_res
);
	import obsd_pkg::*;

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
